// ===== sv/mi_pkg.sv =====
// ----------------------------------------------------------------------------
// mi_pkg: shared definitions of the modular inverse unit
// Word width, port widths, controller/datapath command and status bundles
// and the modular add/subtract helpers used by the datapath.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int WORD_BITS     = 32;
	localparam int IN_DATA_BITS  = ((2 * WORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((WORD_BITS + 7) / 8) * 8;
	localparam int SHIFT_BITS    = $clog2(WORD_BITS);

	// largest divisor alignment: the divisor never moves past the top bit
	localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = SHIFT_BITS'(WORD_BITS - 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS:0]   wide_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture a new item
		logic div_start;  // start a division of x by y
		logic shift_up;   // align divisor one bit higher
		logic dn_a;       // quotient bit: compare/subtract, double accumulator
		logic dn_b;       // add coefficient when quotient bit set, step divisor down
		logic update;     // Euclid step: rotate remainders and coefficients
		logic reducing;   // current division is the initial operand reduction
		logic out_load;   // write result into the output register
	} mi_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic m_small;     // modulus below two
		logic up_ok;       // divisor can be doubled without passing the dividend
		logic k_zero;      // divisor is back at its original alignment
		logic r_new_zero;  // newest remainder is zero, Euclid finished
	} mi_status_t;

	// (x + y) mod m with x, y < m
	function automatic word_t add_mod(word_t x, word_t y, word_t m);
		wide_t sum;
		wide_t m_w;
		sum = {1'b0, x} + {1'b0, y};
		m_w = {1'b0, m};
		if (sum >= m_w) begin
			sum = sum - m_w;
		end
		return sum[WORD_BITS-1:0];
	endfunction

	// (x - y) mod m with x, y < m
	function automatic word_t sub_mod(word_t x, word_t y, word_t m);
		word_t diff;
		diff = x - y;
		if (x < y) begin
			diff = diff + m;
		end
		return diff;
	endfunction

endpackage

// ===== sv/mi_dpath.sv =====
// ----------------------------------------------------------------------------
// mi_dpath: datapath of the modular inverse unit
// Remainder pair, Bezout coefficients, shift-subtract divider with a
// Horner-style quotient times coefficient accumulator, and the result register.
// ----------------------------------------------------------------------------
module mi_dpath import mi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mi_cmd_t    cmd,
	output mi_status_t status,
	input  word_t      modulus,
	input  word_t      operand_value,
	output word_t      inverse,
	output logic       no_inverse
);

	word_t                 m_q;
	word_t                 x_q;    // older remainder (dividend)
	word_t                 y_q;    // newer remainder (divisor)
	word_t                 d_q;    // aligned divisor
	word_t                 rem_q;  // running remainder
	word_t                 acc_q;  // quotient times coefficient, mod m
	word_t                 co_q;   // older coefficient
	word_t                 cn_q;   // newer coefficient
	logic [SHIFT_BITS-1:0] k_q;
	logic                  qbit_q;
	word_t                 inverse_q;
	logic                  no_inv_q;

	logic rem_ge;
	logic no_inv;

	// status and per-cycle decisions
	assign rem_ge            = rem_q >= d_q;
	assign status.m_small    = (m_q[WORD_BITS-1:1] == '0);
	assign status.up_ok      = d_q <= (x_q >> 1);
	assign status.k_zero     = (k_q == '0);
	assign status.r_new_zero = (y_q == '0);
	assign no_inv            = status.m_small || (x_q != word_t'(1));

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q  <= modulus;
			x_q  <= operand_value;
			y_q  <= modulus;
			co_q <= '0;
			cn_q <= word_t'(1);
		end
		if (cmd.div_start) begin
			d_q   <= y_q;
			k_q   <= '0;
			rem_q <= x_q;
			acc_q <= '0;
		end
		if (cmd.shift_up) begin
			d_q <= d_q << 1;
			k_q <= k_q + 1'b1;
		end
		if (cmd.dn_a) begin
			acc_q  <= add_mod(acc_q, acc_q, m_q);
			qbit_q <= rem_ge;
			if (rem_ge) begin
				rem_q <= rem_q - d_q;
			end
		end
		if (cmd.dn_b) begin
			if (qbit_q) begin
				acc_q <= add_mod(acc_q, cn_q, m_q);
			end
			if (!status.k_zero) begin
				d_q <= d_q >> 1;
				k_q <= k_q - 1'b1;
			end
		end
		if (cmd.update) begin
			if (cmd.reducing) begin
				x_q  <= m_q;
				y_q  <= rem_q;
				co_q <= '0;
				cn_q <= word_t'(1);
			end else begin
				x_q  <= y_q;
				y_q  <= rem_q;
				co_q <= cn_q;
				cn_q <= sub_mod(co_q, acc_q, m_q);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			no_inv_q  <= no_inv;
			inverse_q <= no_inv ? '0 : co_q;
		end
	end

	assign inverse    = inverse_q;
	assign no_inverse = no_inv_q;

	// accumulator stays reduced below the modulus
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_b |=> (acc_q < m_q))
		else $error("accumulator not reduced modulo m");

	// a finished division leaves a remainder below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (rem_q < y_q))
		else $error("remainder not below divisor at update");

	// divisor alignment never runs past the word
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_up |-> (k_q < SHIFT_MAX))
		else $error("divisor alignment out of range");

endmodule

// ===== sv/mi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mi_ctrl: controller of the modular inverse unit
// One-hot state machine sequencing reduction, Euclid steps and the
// shift-subtract division, plus the output valid flag.
// ----------------------------------------------------------------------------
module mi_ctrl import mi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  mi_status_t status,
	output mi_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_START = 8'b0000_0010,
		S_UP    = 8'b0000_0100,
		S_DN_A  = 8'b0000_1000,
		S_DN_B  = 8'b0001_0000,
		S_UPD   = 8'b0010_0000,
		S_TEST  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   reducing_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;

	// commands and next state
	always_comb begin
		cmd          = '0;
		cmd.reducing = reducing_q;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (status.m_small) begin
					state_d = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_UP;
				end
			end
			S_UP: begin
				if (status.up_ok) begin
					cmd.shift_up = 1'b1;
				end else begin
					state_d = S_DN_A;
				end
			end
			S_DN_A: begin
				cmd.dn_a = 1'b1;
				state_d  = S_DN_B;
			end
			S_DN_B: begin
				cmd.dn_b = 1'b1;
				state_d  = status.k_zero ? S_UPD : S_DN_A;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_TEST;
			end
			S_TEST: begin
				if (status.r_new_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_UP;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, reduction flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			reducing_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				reducing_q <= 1'b1;
			end else if (cmd.update) begin
				reducing_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !cmd.out_load)
		else $error("waiting result overwritten");

endmodule

// ===== sv/modular_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_unit: modular inverse by the extended Euclidean algorithm
// Input item: modulus and operand; result item: inverse and no-inverse flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request (modulus, operand); m_axis returns one result
//   per request, in order. tuser flags that no inverse exists (gcd not one,
//   operand a multiple of the modulus, or modulus below two); tdata is then 0.
// Operation:
//   one item at a time. The operand is first reduced modulo the modulus, then
//   each Euclid step runs a shift-subtract division: the divisor is first
//   aligned one bit at a time, then each quotient bit takes a compare/subtract
//   step and a modular add into the quotient-times-coefficient accumulator,
//   followed by bookkeeping (update and zero test). The reduction and all Euclid
//   steps share this single divide/accumulate loop; modulus below two skips it.
// Reset and stalls:
//   arst_n clears the controller and the output valid; no other state is
//   kept. A finished result waits in the output register while m_axis_tready
//   is low; the next request is accepted meanwhile and its result waits in
//   the datapath until the output register frees.
// ----------------------------------------------------------------------------
module modular_inverse_unit import mi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // modulus, operand_value
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // inverse
	output logic                     m_axis_tuser    // no_inverse
);

	mi_cmd_t    cmd;
	mi_status_t status;
	word_t      modulus;
	word_t      operand_value;
	word_t      inverse;
	logic       no_inverse;

	// unpack request fields
	assign modulus       = s_axis_tdata[WORD_BITS-1:0];
	assign operand_value = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];

	mi_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	mi_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.modulus       (modulus),
		.operand_value (operand_value),
		.inverse       (inverse),
		.no_inverse    (no_inverse)
	);

	// pack result fields
	assign m_axis_tdata = OUT_DATA_BITS'(inverse);
	assign m_axis_tuser = no_inverse;

endmodule
